>>> sv/assert_macros.svh
// Assertion helpers used by the RTL of the reflectance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define FDR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define FDR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg
// Widths, constants and helper functions for the dielectric Fresnel
// reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

  // Sizes of the arithmetic.
  localparam int unsigned RadW     = 62;  // radicand of the square root
  localparam int unsigned RootW    = 31;  // square root result
  localparam int unsigned SqRemW   = 32;  // square root partial remainder
  localparam int unsigned SqSteps  = RadW / 2;
  localparam int unsigned P1W      = 48;  // nT^2 * c
  localparam int unsigned P2W      = 32;  // nI * c
  localparam int unsigned M1W      = 47;  // nI * r
  localparam int unsigned WideW    = 49;  // widest ratio denominator
  localparam int unsigned DivW     = 32;  // divider operand width
  localparam int unsigned RatioW   = 20;  // fraction bits of a ratio
  localparam int unsigned QW       = RatioW + 1;
  localparam int unsigned SideW    = 1 + 16 + P2W + P1W;
  localparam int unsigned ReflW    = 17;

  localparam logic [ReflW-1:0] ReflOne = ReflW'(65536);

  // Numerator and denominator after normalization.
  typedef struct packed {
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } norm_t;

  // Shift numerator and denominator right together until den < 2^32.
  function automatic norm_t norm_ratio(logic [WideW-1:0] num, logic [WideW-1:0] den);
    logic [4:0]       sh;
    logic [WideW-1:0] n_s;
    logic [WideW-1:0] d_s;
    norm_t            res;
    sh = '0;
    for (int i = 0; i < WideW - DivW; i++) begin
      if (den[DivW + i]) begin
        sh = 5'(i + 1);
      end
    end
    n_s = num >> sh;
    d_s = den >> sh;
    res.num = n_s[DivW-1:0];
    res.den = d_s[DivW-1:0];
    return res;
  endfunction

endpackage

>>> sv/fdr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fdr_sqrt_cell
// One digit step of the integer square root: brings down two radicand bits
// and decides one root bit, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module fdr_sqrt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [fdr_pkg::RadW-1:0]      rad_i,
  input  logic [fdr_pkg::SqRemW-1:0]    rem_i,
  input  logic [fdr_pkg::RootW-1:0]     root_i,
  input  logic [fdr_pkg::SideW-1:0]     side_i,
  output logic                          vld_o,
  output logic [fdr_pkg::RadW-1:0]      rad_o,
  output logic [fdr_pkg::SqRemW-1:0]    rem_o,
  output logic [fdr_pkg::RootW-1:0]     root_o,
  output logic [fdr_pkg::SideW-1:0]     side_o
);

  logic [fdr_pkg::SqRemW+1:0] rem_sh;
  logic [fdr_pkg::SqRemW+1:0] trial;
  logic [fdr_pkg::SqRemW+1:0] diff;
  logic                       vld_q;
  logic [fdr_pkg::RadW-1:0]   rad_d, rad_q;
  logic [fdr_pkg::SqRemW-1:0] rem_d, rem_q;
  logic [fdr_pkg::RootW-1:0]  root_d, root_q;
  logic [fdr_pkg::SideW-1:0]  side_q;

  // Trial subtraction of (4*root + 1) from the shifted remainder.
  always_comb begin
    rem_sh = {rem_i, rad_i[fdr_pkg::RadW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem_sh - trial;
    rad_d  = {rad_i[fdr_pkg::RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d  = diff[fdr_pkg::SqRemW-1:0];
      root_d = {root_i[fdr_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[fdr_pkg::SqRemW-1:0];
      root_d = {root_i[fdr_pkg::RootW-2:0], 1'b0};
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

>>> sv/fdr_div_cell.sv
// ----------------------------------------------------------------------------
// fdr_div_cell
// One step of restoring division: shifts in one dividend bit, decides one
// quotient bit and passes the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module fdr_div_cell #(
  parameter int unsigned SW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [fdr_pkg::DivW-1:0]    rem_i,
  input  logic [fdr_pkg::DivW-1:0]    den_i,
  input  logic [fdr_pkg::QW-1:0]      lo_i,
  input  logic [fdr_pkg::QW-1:0]      quo_i,
  input  logic [SW-1:0]               side_i,
  output logic                        vld_o,
  output logic [fdr_pkg::DivW-1:0]    rem_o,
  output logic [fdr_pkg::DivW-1:0]    den_o,
  output logic [fdr_pkg::QW-1:0]      lo_o,
  output logic [fdr_pkg::QW-1:0]      quo_o,
  output logic [SW-1:0]               side_o
);

  logic [fdr_pkg::DivW:0]   rem_sh;
  logic [fdr_pkg::DivW:0]   diff;
  logic                     vld_q;
  logic [fdr_pkg::DivW-1:0] rem_d, rem_q;
  logic [fdr_pkg::DivW-1:0] den_q;
  logic [fdr_pkg::QW-1:0]   lo_q;
  logic [fdr_pkg::QW-1:0]   quo_d, quo_q;
  logic [SW-1:0]            side_q;

  // Compare and subtract.
  always_comb begin
    rem_sh = {rem_i, lo_i[fdr_pkg::QW-1]};
    diff   = rem_sh - {1'b0, den_i};
    if (rem_sh >= {1'b0, den_i}) begin
      rem_d = diff[fdr_pkg::DivW-1:0];
      quo_d = {quo_i[fdr_pkg::QW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[fdr_pkg::DivW-1:0];
      quo_d = {quo_i[fdr_pkg::QW-2:0], 1'b0};
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      lo_q   <= {lo_i[fdr_pkg::QW-2:0], 1'b0};
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign lo_o   = lo_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

>>> sv/fresnel_dielectric_reflectance.sv
// A result passes stages A-D, the root chain, E-G, the divider chains, H and O.
// Throughput: one transaction per cycle while not stalled; the 31-cell square
// root chain and the two 21-cell divider chains advance one cell per cycle.
// A stalled output holds the whole pipeline, so stall_o follows stall_i then.
// Reset clears every valid bit asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a smooth dielectric boundary, computed
// by a fixed-point pipeline built from square root and divider cell chains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fresnel_dielectric_reflectance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] cos_incident_i,
  input  logic [15:0] eta_incident_i,
  input  logic [15:0] eta_transmitted_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [16:0] reflectance_o,
  output logic        total_internal_o
);

  localparam int unsigned SqN  = fdr_pkg::SqSteps;
  localparam int unsigned DivN = fdr_pkg::QW;

  logic en;

  // Stage A: fold the sign of the cosine and swap the indices.
  logic        a_vld_q;
  logic [15:0] a_c_q, a_ni_q, a_nt_q;
  logic        entering;

  // Stage B: squares.
  logic        b_vld_q;
  logic [15:0] b_c_q, b_ni_q;
  logic [31:0] b_cc_q, b_ni2_q, b_nt2_q;

  // Stage C: products for the test and the ratios.
  logic        c_vld_q;
  logic [30:0] s2;
  logic [62:0] c_lhs_q;
  logic [61:0] c_rhs_q;
  logic [fdr_pkg::P1W-1:0] c_p1_q;
  logic [fdr_pkg::P2W-1:0] c_p2_q;
  logic [15:0] c_ni_q;

  // Stage D: total internal reflection test and radicand.
  logic        d_vld_q;
  logic        tir;
  logic [62:0] d_diff;
  logic [fdr_pkg::RadW-1:0]  d_rad_q;
  logic [fdr_pkg::SideW-1:0] d_side_q;

  // Square root chain.
  logic                        sq_vld  [0:SqN];
  logic [fdr_pkg::RadW-1:0]    sq_rad  [0:SqN];
  logic [fdr_pkg::SqRemW-1:0]  sq_rem  [0:SqN];
  logic [fdr_pkg::RootW-1:0]   sq_root [0:SqN];
  logic [fdr_pkg::SideW-1:0]   sq_side [0:SqN];

  // Stage E: second terms of the ratios.
  logic        e_vld_q, e_tir_q;
  logic [fdr_pkg::P1W-1:0] e_p1_q;
  logic [fdr_pkg::M1W-1:0] e_m1_q;
  logic [fdr_pkg::P2W-1:0] e_p2_q;
  logic [fdr_pkg::RootW-1:0] e_m2_q;
  logic [fdr_pkg::SideW-1:0] sq_out;

  // Stage F: sums and differences.
  logic        f_vld_q, f_tir_q;
  logic [fdr_pkg::WideW-1:0] f_num1_q, f_den1_q, f_num2_q, f_den2_q;
  logic [fdr_pkg::WideW-1:0] m1_x, p1_x, p2_x, m2_x;

  // Stage G: normalization and divider set-up.
  logic        g_vld_q, g_tir_q, g_z1_q, g_z2_q;
  fdr_pkg::norm_t n1, n2;
  logic [52:0] dvd1, dvd2;
  logic [fdr_pkg::DivW-1:0] g_rem1_q, g_den1_q, g_rem2_q, g_den2_q;
  logic [fdr_pkg::QW-1:0]   g_lo1_q, g_lo2_q;

  // Divider chains.
  logic                      dv1_vld [0:DivN];
  logic [fdr_pkg::DivW-1:0]  dv1_rem [0:DivN];
  logic [fdr_pkg::DivW-1:0]  dv1_den [0:DivN];
  logic [fdr_pkg::QW-1:0]    dv1_lo  [0:DivN];
  logic [fdr_pkg::QW-1:0]    dv1_quo [0:DivN];
  logic [1:0]                dv1_side[0:DivN];
  logic                      dv2_vld [0:DivN];
  logic [fdr_pkg::DivW-1:0]  dv2_rem [0:DivN];
  logic [fdr_pkg::DivW-1:0]  dv2_den [0:DivN];
  logic [fdr_pkg::QW-1:0]    dv2_lo  [0:DivN];
  logic [fdr_pkg::QW-1:0]    dv2_quo [0:DivN];
  logic [0:0]                dv2_side[0:DivN];

  // Stage H: squared ratios.
  logic        h_vld_q, h_tir_q;
  logic [fdr_pkg::QW-1:0]   q1, q2;
  logic [2*fdr_pkg::QW-1:0] h_sq1_q, h_sq2_q;

  // Output stage.
  logic        o_vld_q, o_tir_q;
  logic [fdr_pkg::ReflW-1:0] o_refl_q;
  logic [2*fdr_pkg::QW:0]    sum_r;
  logic [2*fdr_pkg::QW:0]    refl_w;
  logic [fdr_pkg::ReflW-1:0] refl_sat;

  // The whole pipeline advances unless a held result is stalled.
  assign en      = !(o_vld_q && stall_i);
  assign stall_o = !en;

  // Stage A.
  assign entering = !cos_incident_i[15] && (cos_incident_i != 16'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q  <= cos_incident_i[15] ? 16'(~cos_incident_i + 16'd1) : cos_incident_i;
      a_ni_q <= entering ? eta_incident_i : eta_transmitted_i;
      a_nt_q <= entering ? eta_transmitted_i : eta_incident_i;
    end
  end

  // Stage B.
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_c_q   <= a_c_q;
      b_ni_q  <= a_ni_q;
      b_cc_q  <= a_c_q * a_c_q;
      b_ni2_q <= a_ni_q * a_ni_q;
      b_nt2_q <= a_nt_q * a_nt_q;
    end
  end

  // Stage C: sin^2 of the incident angle and the cross products.
  assign s2 = 31'(32'h4000_0000 - b_cc_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_lhs_q <= 63'(b_ni2_q) * 63'(s2);
      c_rhs_q <= {b_nt2_q, 30'd0};
      c_p1_q  <= 48'(b_nt2_q) * 48'(b_c_q);
      c_p2_q  <= 32'(b_ni_q) * 32'(b_c_q);
      c_ni_q  <= b_ni_q;
    end
  end

  // Stage D.
  assign tir    = c_lhs_q >= {1'b0, c_rhs_q};
  assign d_diff = {1'b0, c_rhs_q} - c_lhs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_rad_q  <= tir ? '0 : d_diff[fdr_pkg::RadW-1:0];
      d_side_q <= {tir, c_ni_q, c_p2_q, c_p1_q};
    end
  end

  // Square root chain.
  assign sq_vld[0]  = d_vld_q;
  assign sq_rad[0]  = d_rad_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = d_side_q;

  for (genvar i = 0; i < SqN; i++) begin : g_sq
    fdr_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Stage E.
  assign sq_out = sq_side[SqN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_tir_q <= sq_out[fdr_pkg::SideW-1];
      e_p1_q  <= sq_out[fdr_pkg::P1W-1:0];
      e_p2_q  <= sq_out[fdr_pkg::P1W +: fdr_pkg::P2W];
      e_m1_q  <= 47'(sq_out[fdr_pkg::P1W + fdr_pkg::P2W +: 16]) * 47'(sq_root[SqN]);
      e_m2_q  <= sq_root[SqN];
    end
  end

  // Stage F.
  assign p1_x = fdr_pkg::WideW'(e_p1_q);
  assign m1_x = fdr_pkg::WideW'(e_m1_q);
  assign p2_x = fdr_pkg::WideW'(e_p2_q);
  assign m2_x = fdr_pkg::WideW'(e_m2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_tir_q  <= e_tir_q;
      f_den1_q <= p1_x + m1_x;
      f_num1_q <= (p1_x > m1_x) ? p1_x - m1_x : m1_x - p1_x;
      f_den2_q <= p2_x + m2_x;
      f_num2_q <= (p2_x > m2_x) ? p2_x - m2_x : m2_x - p2_x;
    end
  end

  // Stage G: dividend is num * 2^20 + den / 2.
  assign n1   = fdr_pkg::norm_ratio(f_num1_q, f_den1_q);
  assign n2   = fdr_pkg::norm_ratio(f_num2_q, f_den2_q);
  assign dvd1 = {n1.num, 20'd0} + 53'(n1.den[fdr_pkg::DivW-1:1]);
  assign dvd2 = {n2.num, 20'd0} + 53'(n2.den[fdr_pkg::DivW-1:1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_tir_q  <= f_tir_q;
      g_z1_q   <= (f_den1_q == '0);
      g_z2_q   <= (f_den2_q == '0);
      g_rem1_q <= dvd1[52:21];
      g_lo1_q  <= dvd1[20:0];
      g_den1_q <= n1.den;
      g_rem2_q <= dvd2[52:21];
      g_lo2_q  <= dvd2[20:0];
      g_den2_q <= n2.den;
    end
  end

  // Divider chains, one per amplitude ratio.
  assign dv1_vld[0]  = g_vld_q;
  assign dv1_rem[0]  = g_rem1_q;
  assign dv1_den[0]  = g_den1_q;
  assign dv1_lo[0]   = g_lo1_q;
  assign dv1_quo[0]  = '0;
  assign dv1_side[0] = {g_tir_q, g_z1_q};
  assign dv2_vld[0]  = g_vld_q;
  assign dv2_rem[0]  = g_rem2_q;
  assign dv2_den[0]  = g_den2_q;
  assign dv2_lo[0]   = g_lo2_q;
  assign dv2_quo[0]  = '0;
  assign dv2_side[0] = g_z2_q;

  for (genvar i = 0; i < DivN; i++) begin : g_div
    fdr_div_cell #(.SW(2)) u_cell1 (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv1_vld[i]),
      .rem_i  (dv1_rem[i]),
      .den_i  (dv1_den[i]),
      .lo_i   (dv1_lo[i]),
      .quo_i  (dv1_quo[i]),
      .side_i (dv1_side[i]),
      .vld_o  (dv1_vld[i+1]),
      .rem_o  (dv1_rem[i+1]),
      .den_o  (dv1_den[i+1]),
      .lo_o   (dv1_lo[i+1]),
      .quo_o  (dv1_quo[i+1]),
      .side_o (dv1_side[i+1])
    );
    fdr_div_cell #(.SW(1)) u_cell2 (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv2_vld[i]),
      .rem_i  (dv2_rem[i]),
      .den_i  (dv2_den[i]),
      .lo_i   (dv2_lo[i]),
      .quo_i  (dv2_quo[i]),
      .side_i (dv2_side[i]),
      .vld_o  (dv2_vld[i+1]),
      .rem_o  (dv2_rem[i+1]),
      .den_o  (dv2_den[i+1]),
      .lo_o   (dv2_lo[i+1]),
      .quo_o  (dv2_quo[i+1]),
      .side_o (dv2_side[i+1])
    );
  end

  // Stage H: a zero denominator counts as a ratio of one.
  assign q1 = dv1_side[DivN][0] ? fdr_pkg::QW'(1 << fdr_pkg::RatioW) : dv1_quo[DivN];
  assign q2 = dv2_side[DivN][0] ? fdr_pkg::QW'(1 << fdr_pkg::RatioW) : dv2_quo[DivN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_tir_q <= dv1_side[DivN][1];
      h_sq1_q <= 42'(q1) * 42'(q1);
      h_sq2_q <= 42'(q2) * 42'(q2);
    end
  end

  // Output stage: round the mean to Q1.16 and saturate.
  assign sum_r  = 43'(h_sq1_q) + 43'(h_sq2_q) + 43'(1 << 24);
  assign refl_w = sum_r >> 25;
  assign refl_sat = (refl_w > 43'(fdr_pkg::ReflOne)) ? fdr_pkg::ReflOne
                                                     : refl_w[fdr_pkg::ReflW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_tir_q  <= h_tir_q;
      o_refl_q <= h_tir_q ? fdr_pkg::ReflOne : refl_sat;
    end
  end

  // Valid bits of the stages outside the cell chains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= sq_vld[SqN];
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= dv1_vld[DivN];
      o_vld_q <= h_vld_q;
    end
  end

  assign valid_o          = o_vld_q;
  assign reflectance_o    = o_refl_q;
  assign total_internal_o = o_tir_q;

  // Checks.
  `FDR_ASSERT_IMPL(a_tir_one, clk_i, rst_ni, valid_o && total_internal_o,
    reflectance_o == fdr_pkg::ReflOne, "total internal reflection without full reflectance")
  `FDR_ASSERT_IMPL(a_refl_range, clk_i, rst_ni, valid_o,
    reflectance_o <= fdr_pkg::ReflOne, "reflectance above one")
  `FDR_ASSERT_IMPL(a_stall_held, clk_i, rst_ni, stall_o,
    valid_o && stall_i, "pipeline stalled without a held result")
  `FDR_ASSERT(a_lanes_even, clk_i, rst_ni, dv1_vld[DivN] == dv2_vld[DivN],
    "divider lanes out of step")

endmodule
